[design/cbsfe_pkg.sv]
// Package for the CRC-16 byte-stuffing frame encoder.
// Holds the framing constants, the CRC table function and the escape helper.
// No dependencies.
`default_nettype none

package cbsfe_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  ESC_XOR   = 8'h20;
	localparam logic [7:0]  STAMP_BIT = 8'h40;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CRC_INIT  = 16'h0000;

	localparam logic [4:0]  POS_MARK  = 5'd4;
	localparam logic [4:0]  POS_STAMP = 5'd13;
	localparam logic [4:0]  POS_LAST  = 5'd20;
	localparam logic [4:0]  POS_SAT   = 5'd21;

	// One escaped byte: up to two bytes, first one in the low half.
	typedef struct packed {
		logic [15:0] bytes;
		logic [1:0]  len;
	} esc_piece_t;

	// Table entry: idx << 8 shifted through eight MSB-first polynomial steps.
	function automatic logic [15:0] crc_tab(input logic [7:0] idx);
		logic [15:0] r;
		r = {idx, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

	function automatic esc_piece_t escape_byte(input logic [7:0] b);
		esc_piece_t p;
		if (b == FLAG_BYTE || b == ESC_BYTE) begin
			p.bytes = {b ^ ESC_XOR, ESC_BYTE};
			p.len   = 2'd2;
		end else begin
			p.bytes = {8'h00, b};
			p.len   = 2'd1;
		end
		return p;
	endfunction

endpackage

`default_nettype wire

[design/crc16_byte_stuffing_frame_encoder_top.sv]
// Top level of the CRC-16 byte-stuffing frame encoder.
// Depends on cbsfe_pkg for constants, the CRC table and the escape helper.
`default_nettype none

// Frame encoder: each accepted body byte is stamped, folded into a CRC-16
// (poly 0x1021, init 0) and turned into a burst of 1 to 8 output bytes: the
// opening 0x7E when it starts a frame, the byte itself (0x7E/0x7D escaped as
// 0x7D, byte ^ 0x20), and on the last byte the escaped CRC high and low bytes
// and the closing 0x7E. Body byte 4 gets bit 0x40 set; body bytes 13 to 20 are
// replaced by the 64-bit timestamp sampled with the first byte, most
// significant byte first. The whole burst for one transaction is built
// combinationally into a result register and then streamed out one byte per
// cycle while m_axis_tready is high. The output port is the limit: a new input
// transaction is accepted in the same cycle as the final byte of the previous
// burst leaves, so bytes that need a one-byte burst flow at one per cycle
// while the output is not stalled.
// m_axis_tlast marks the last byte of each burst, m_axis_tuser the closing
// flag of a frame.
module crc16_byte_stuffing_frame_encoder_top
	import cbsfe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,  // [7:0] data_byte, [71:8] stamp_ms
	input  wire logic        s_axis_tlast,  // last_byte

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
	output logic             m_axis_tlast,  // run_last
	output logic             m_axis_tuser   // [0] frame_end
);

	// Frame state
	logic [15:0] crc_q;
	logic        in_frame_q;
	logic [4:0]  pos_q;
	logic [63:0] stamp_q;

	// Result register: burst bytes packed from the low end
	logic [63:0] res_data_q;
	logic [3:0]  res_cnt_q;
	logic [2:0]  res_idx_q;
	logic        res_end_q;
	logic        res_vld_q;

	logic        take, fin, acc;
	logic [7:0]  din;
	logic [63:0] stamp_cur;
	logic [15:0] crc_cur, crc_new;
	logic [4:0]  pos_cur, pos_nxt, stamp_off;
	logic [7:0]  body;
	esc_piece_t  p_body, p_hi, p_lo;
	logic [63:0] bvec;
	logic [3:0]  bcnt;

	assign din = s_axis_tdata[7:0];

	// A closed frame restarts from the incoming timestamp, zero CRC and position.
	assign stamp_cur = in_frame_q ? stamp_q : s_axis_tdata[71:8];
	assign crc_cur   = in_frame_q ? crc_q   : CRC_INIT;
	assign pos_cur   = in_frame_q ? pos_q   : 5'd0;
	assign pos_nxt   = (pos_cur < POS_SAT) ? pos_cur + 5'd1 : pos_cur;
	assign stamp_off = POS_LAST - pos_cur;

	always_comb begin
		body = din;
		if (pos_cur == POS_MARK) begin
			body = din | STAMP_BIT;
		end else if (pos_cur >= POS_STAMP && pos_cur <= POS_LAST) begin
			body = stamp_cur[{stamp_off[2:0], 3'b000} +: 8];
		end
	end

	assign crc_new = crc_tab(crc_cur[15:8]) ^ {crc_cur[7:0], 8'h00} ^ {8'h00, body};
	assign p_body  = escape_byte(body);
	assign p_hi    = escape_byte(crc_new[15:8]);
	assign p_lo    = escape_byte(crc_new[7:0]);

	// Assemble the burst: opening flag, body, then the trailer on the last byte.
	always_comb begin
		bvec = 64'h0;
		bcnt = 4'd0;
		if (!in_frame_q) begin
			bvec[7:0] = FLAG_BYTE;
			bcnt      = 4'd1;
		end
		bvec = bvec | ({48'h0, p_body.bytes} << {bcnt, 3'b000});
		bcnt = bcnt + {2'b00, p_body.len};
		if (s_axis_tlast) begin
			bvec = bvec | ({48'h0, p_hi.bytes} << {bcnt, 3'b000});
			bcnt = bcnt + {2'b00, p_hi.len};
			bvec = bvec | ({48'h0, p_lo.bytes} << {bcnt, 3'b000});
			bcnt = bcnt + {2'b00, p_lo.len};
			bvec = bvec | ({56'h0, FLAG_BYTE} << {bcnt, 3'b000});
			bcnt = bcnt + 4'd1;
		end
	end

	// Handshakes: take the next transaction as the last burst byte leaves.
	assign take          = res_vld_q && m_axis_tready;
	assign fin           = take && ({1'b0, res_idx_q} == res_cnt_q - 4'd1);
	assign s_axis_tready = !res_vld_q || fin;
	assign acc           = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = res_vld_q;
	assign m_axis_tdata  = res_data_q[{res_idx_q, 3'b000} +: 8];
	assign m_axis_tlast  = ({1'b0, res_idx_q} == res_cnt_q - 4'd1);
	assign m_axis_tuser  = res_end_q && m_axis_tlast;

	// Frame state: advance on every accepted transaction, clear at frame end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_INIT;
			in_frame_q <= 1'b0;
			pos_q      <= 5'd0;
			stamp_q    <= 64'h0;
		end else if (acc) begin
			stamp_q <= stamp_cur;
			if (s_axis_tlast) begin
				crc_q      <= CRC_INIT;
				pos_q      <= 5'd0;
				in_frame_q <= 1'b0;
			end else begin
				crc_q      <= crc_new;
				pos_q      <= pos_nxt;
				in_frame_q <= 1'b1;
			end
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
			res_idx_q <= 3'd0;
			res_cnt_q <= 4'd1;
			res_end_q <= 1'b0;
		end else if (acc) begin
			res_vld_q <= 1'b1;
			res_idx_q <= 3'd0;
			res_cnt_q <= bcnt;
			res_end_q <= s_axis_tlast;
		end else if (fin) begin
			res_vld_q <= 1'b0;
		end else if (take) begin
			res_idx_q <= res_idx_q + 3'd1;
		end
	end

	// Burst payload, no reset needed
	always_ff @(posedge clk) begin
		if (acc) begin
			res_data_q <= bvec;
		end
	end

endmodule

`default_nettype wire

[design/cbsfe_checker.sv]
// Port-level checker for the CRC-16 byte-stuffing frame encoder.
// Bound to crc16_byte_stuffing_frame_encoder_top; uses cbsfe_pkg constants.
`default_nettype none

module cbsfe_checker
	import cbsfe_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata,
	input wire logic        m_axis_tlast,
	input wire logic        m_axis_tuser
);

	// Closing flag always ends the burst of its transaction.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("frame end outside burst end");

	// Closing flag carries the flag byte.
	a_end_is_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == FLAG_BYTE)
		else $error("frame end without flag byte");

	// An empty output side never blocks input.
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output empty");

	// Stalled output holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output changed under stall");

	// Escape byte never ends a burst.
	a_esc_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata == ESC_BYTE |-> !m_axis_tlast)
		else $error("burst ends on escape byte");

endmodule

bind crc16_byte_stuffing_frame_encoder_top cbsfe_checker u_cbsfe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
